[src/rgbds_pkg.sv]
// ----------------------------------------------------------------------------
// rgbds_pkg
// Shared types and constants for the RGB565 box-average downscaler.
// ----------------------------------------------------------------------------
package rgbds_pkg;

  localparam int MAX_SOURCE_WIDTH  = 2048;
  localparam int MAX_SOURCE_HEIGHT = 2048;
  localparam int MAX_TARGET_WIDTH  = 1024;

  localparam int SIZE_W  = 12;
  localparam int POS_W   = 11;
  localparam int PROD_W  = 24;
  localparam int RED_W   = 27;
  localparam int GREEN_W = 28;
  localparam int BLUE_W  = 27;
  localparam int CNT_W   = 23;
  localparam int EPOCH_W = 8;
  localparam int QUO_W   = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd3;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [RED_W-1:0]   red;
    logic [GREEN_W-1:0] green;
    logic [BLUE_W-1:0]  blue;
    logic [CNT_W-1:0]   cnt;
  } col_entry_t;

  localparam int ENTRY_W = $bits(col_entry_t);

endpackage

[src/rgb565_box_average_downscaler.sv]
// ----------------------------------------------------------------------------
// rgb565_box_average_downscaler
// Box-average downscaler: RGB565 raster in, averaged RGB888 pixels out.
// ----------------------------------------------------------------------------
//  channel  handshake           payload
//  in       in_valid/in_stall   in_pixel_word, in_frame_start
//  out      out_valid/out_stall colour values, out_column, out_row, out_frame_last
//  cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
//  a pixel is read from the column memory, then added and written back
//  a pixel that closes a region then runs 6 divider steps, waits for the
//  divider done flag and loads the output register
//  after reset, and when a frame start or configuration write finds the
//  epoch full, a clearing pass sweeps the column memory with in_stall high
//  a result waiting on out_stall holds back only the next region close
// ----------------------------------------------------------------------------
module rgb565_box_average_downscaler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_pixel_word,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_blue_value,
  output logic [7:0]  out_green_value,
  output logic [7:0]  out_red_value,
  output logic [9:0]  out_column,
  output logic [10:0] out_row,
  output logic        out_frame_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [rgbds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [11:0] cfg_data
);
  import rgbds_pkg::*;

  localparam int TCW = (MAX_TARGET_WIDTH > 1) ? $clog2(MAX_TARGET_WIDTH) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] st_r, st_nxt;

  // configuration
  logic [SIZE_W-1:0] src_w_r, src_h_r, dst_h_r;
  logic [10:0]       dst_w_r;
  logic [SIZE_W-1:0] sw, sh, dw, dh, hi_w;
  logic              cfg_wr;

  // position state
  logic [POS_W-1:0]  sc_r, sc_nxt, sr_r, sr_nxt, tr_r, tr_nxt;
  logic [TCW-1:0]    tc_r, tc_nxt;
  logic [PROD_W-1:0] acol_r, acol_nxt, bcol_r, bcol_nxt;
  logic [PROD_W-1:0] arow_r, arow_nxt, brow_r, brow_nxt;
  logic              pend_r;

  // current values seen by an accepted pixel
  logic [POS_W-1:0]  c_sc, c_sr, c_tr;
  logic [TCW-1:0]    c_tc;
  logic [PROD_W-1:0] c_acol, c_bcol, c_arow, c_brow;
  logic              col_last, row_last, row_wrap;

  // clearing and epoch
  logic               clr_r, clr_nxt;
  logic [TCW-1:0]     caddr_r, caddr_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic               epoch_full;

  logic in_acc;

  // held item
  logic [15:0]      px_r;
  logic [TCW-1:0]   htc_r;
  logic [POS_W-1:0] htr_r;
  logic             hlast_r, hemit_r;

  // memory
  logic             mem_we;
  logic [TCW-1:0]   mem_waddr;
  col_entry_t       mem_wdata, mem_rdata, old_e, new_e;

  // divider
  logic                div_start, div_done;
  logic [QUO_W-1:0]    q_red, q_green, q_blue;

  // output register
  logic              out_valid_r, out_free;
  logic [7:0]        ob_r, og_r, orr_r;
  logic [9:0]        ocol_r;
  logic [10:0]       orow_r;
  logic              olast_r;

  // effective sizes
  always_comb begin
    sw = (src_w_r == '0) ? SIZE_W'(1) :
         (src_w_r > SIZE_W'(MAX_SOURCE_WIDTH)) ? SIZE_W'(MAX_SOURCE_WIDTH) : src_w_r;
    sh = (src_h_r == '0) ? SIZE_W'(1) :
         (src_h_r > SIZE_W'(MAX_SOURCE_HEIGHT)) ? SIZE_W'(MAX_SOURCE_HEIGHT) : src_h_r;
    hi_w = ({1'b0, sw} > 13'(MAX_TARGET_WIDTH)) ? SIZE_W'(MAX_TARGET_WIDTH) : sw;
    dw = (dst_w_r == '0) ? SIZE_W'(1) :
         ({1'b0, dst_w_r} > hi_w) ? hi_w : {1'b0, dst_w_r};
    dh = (dst_h_r == '0) ? SIZE_W'(1) : (dst_h_r > sh) ? sh : dst_h_r;
  end

  assign cfg_ready  = 1'b1;
  assign cfg_wr     = cfg_valid && (cfg_index <= REG_TARGET_HEIGHT);
  assign epoch_full = (epoch_r == '1);
  assign in_stall   = !((st_r == ST_IDLE) && !clr_r && !pend_r &&
                        !(in_frame_start && epoch_full));
  assign in_acc     = in_valid && !in_stall;

  // region and row decisions
  always_comb begin
    c_sc   = in_frame_start ? '0 : sc_r;
    c_sr   = in_frame_start ? '0 : sr_r;
    c_tc   = in_frame_start ? '0 : tc_r;
    c_tr   = in_frame_start ? '0 : tr_r;
    c_acol = in_frame_start ? (PROD_W'(dw) << 1) : acol_r;
    c_bcol = in_frame_start ? PROD_W'(sw) : bcol_r;
    c_arow = in_frame_start ? (PROD_W'(dh) << 1) : arow_r;
    c_brow = in_frame_start ? PROD_W'(sh) : brow_r;
    col_last = (c_acol > c_bcol) || ((SIZE_W'(c_sc) + SIZE_W'(1)) >= sw);
    row_last = (c_arow > c_brow) || ((SIZE_W'(c_sr) + SIZE_W'(1)) >= sh);
    row_wrap = (SIZE_W'(c_sc) + SIZE_W'(1)) >= sw;
  end

  always_comb begin
    sc_nxt = sc_r; sr_nxt = sr_r; tc_nxt = tc_r; tr_nxt = tr_r;
    acol_nxt = acol_r; bcol_nxt = bcol_r; arow_nxt = arow_r; brow_nxt = brow_r;
    if (pend_r) begin
      sc_nxt = '0; sr_nxt = '0; tc_nxt = '0; tr_nxt = '0;
      acol_nxt = PROD_W'(dw) << 1; bcol_nxt = PROD_W'(sw);
      arow_nxt = PROD_W'(dh) << 1; brow_nxt = PROD_W'(sh);
    end else if (in_acc) begin
      sc_nxt = c_sc + POS_W'(1); sr_nxt = c_sr; tc_nxt = c_tc; tr_nxt = c_tr;
      acol_nxt = c_acol + PROD_W'(dw); bcol_nxt = c_bcol;
      arow_nxt = c_arow; brow_nxt = c_brow;
      if (row_wrap) begin
        sc_nxt = '0; tc_nxt = '0;
        acol_nxt = PROD_W'(dw) << 1; bcol_nxt = PROD_W'(sw);
        if ((SIZE_W'(c_sr) + SIZE_W'(1)) >= sh) begin
          sr_nxt = '0; tr_nxt = '0;
          arow_nxt = PROD_W'(dh) << 1; brow_nxt = PROD_W'(sh);
        end else begin
          sr_nxt = c_sr + POS_W'(1);
          arow_nxt = c_arow + PROD_W'(dh);
          if (row_last && ((SIZE_W'(c_tr) + SIZE_W'(1)) < dh)) begin
            tr_nxt = c_tr + POS_W'(1);
            brow_nxt = c_brow + PROD_W'(sh);
          end
        end
      end else if (col_last && ((SIZE_W'(c_tc) + SIZE_W'(1)) < dw)) begin
        tc_nxt = c_tc + TCW'(1);
        bcol_nxt = c_bcol + PROD_W'(sw);
      end
    end
  end

  // epoch and clearing pass
  always_comb begin
    clr_nxt = clr_r; caddr_nxt = caddr_r; epoch_nxt = epoch_r;
    if (clr_r) begin
      caddr_nxt = caddr_r + TCW'(1);
      if (caddr_r == TCW'(MAX_TARGET_WIDTH - 1)) begin
        clr_nxt = 1'b0;
      end
    end
    if (cfg_wr && !clr_r) begin
      if (epoch_full) begin
        clr_nxt = 1'b1; caddr_nxt = '0; epoch_nxt = '0;
      end else begin
        epoch_nxt = epoch_r + EPOCH_W'(1);
      end
    end else if (in_acc && in_frame_start) begin
      epoch_nxt = epoch_r + EPOCH_W'(1);
    end else if ((st_r == ST_IDLE) && !clr_r && !pend_r && in_valid &&
                 in_frame_start && epoch_full) begin
      clr_nxt = 1'b1; caddr_nxt = '0; epoch_nxt = '0;
    end
  end

  // read-modify-write of the column entry, or a clearing write
  always_comb begin
    old_e = (mem_rdata.tag == epoch_r) ? mem_rdata : '0;
    new_e.tag   = epoch_r;
    new_e.red   = old_e.red   + RED_W'(px_r[15:11]);
    new_e.green = old_e.green + GREEN_W'(px_r[10:5]);
    new_e.blue  = old_e.blue  + BLUE_W'(px_r[4:0]);
    new_e.cnt   = old_e.cnt   + CNT_W'(1);
    mem_we    = clr_r || (st_r == ST_ADD);
    mem_waddr = clr_r ? caddr_r : htc_r;
    if (clr_r) begin
      mem_wdata = '0;
    end else if (hemit_r) begin
      mem_wdata = '0;
      mem_wdata.tag = epoch_r;
    end else begin
      mem_wdata = new_e;
    end
  end

  assign div_start = (st_r == ST_ADD) && hemit_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_acc) st_nxt = ST_ADD;
      ST_ADD:  st_nxt = hemit_r ? ST_DIV : ST_IDLE;
      ST_DIV:  if (div_done) st_nxt = ST_OUT;
      ST_OUT:  if (out_free) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  rgbds_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TARGET_WIDTH),
    .AW    (TCW)
  ) u_col_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_acc),
    .raddr (c_tc),
    .rdata (mem_rdata)
  );

  rgbds_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .num_red   (GREEN_W'(new_e.red)),
    .num_green (new_e.green),
    .num_blue  (GREEN_W'(new_e.blue)),
    .den       (new_e.cnt),
    .done      (div_done),
    .quo_red   (q_red),
    .quo_green (q_green),
    .quo_blue  (q_blue)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      src_w_r     <= 12'd1024;
      src_h_r     <= 12'd768;
      dst_w_r     <= 11'd800;
      dst_h_r     <= 12'd600;
      pend_r      <= 1'b1;
      clr_r       <= 1'b1;
      caddr_r     <= '0;
      epoch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      clr_r   <= clr_nxt;
      caddr_r <= caddr_nxt;
      epoch_r <= epoch_nxt;
      pend_r  <= cfg_wr;
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_SOURCE_WIDTH:  src_w_r <= cfg_data;
          REG_SOURCE_HEIGHT: src_h_r <= cfg_data;
          REG_TARGET_WIDTH:  dst_w_r <= cfg_data[10:0];
          REG_TARGET_HEIGHT: dst_h_r <= cfg_data;
          default: ;
        endcase
      end
      if ((st_r == ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // position registers, held item and output payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r <= '0; sr_r <= '0; tc_r <= '0; tr_r <= '0;
      acol_r <= '0; bcol_r <= '0; arow_r <= '0; brow_r <= '0;
    end else begin
      sc_r <= sc_nxt; sr_r <= sr_nxt; tc_r <= tc_nxt; tr_r <= tr_nxt;
      acol_r <= acol_nxt; bcol_r <= bcol_nxt;
      arow_r <= arow_nxt; brow_r <= brow_nxt;
    end
    if (in_acc) begin
      px_r    <= in_pixel_word;
      htc_r   <= c_tc;
      htr_r   <= c_tr;
      hemit_r <= col_last && row_last;
      hlast_r <= ((SIZE_W'(c_tc) + SIZE_W'(1)) >= dw) &&
                 ((SIZE_W'(c_tr) + SIZE_W'(1)) >= dh);
    end
    if ((st_r == ST_OUT) && out_free) begin
      ob_r    <= {q_blue[4:0], 3'b000};
      og_r    <= {q_green[5:0], 2'b00};
      orr_r   <= {q_red[4:0], 3'b000};
      ocol_r  <= 10'(htc_r);
      orow_r  <= htr_r;
      olast_r <= hlast_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_blue_value  = ob_r;
  assign out_green_value = og_r;
  assign out_red_value   = orr_r;
  assign out_column      = ocol_r;
  assign out_row         = orow_r;
  assign out_frame_last  = olast_r;

endmodule

[src/rgbds_ram.sv]
// ----------------------------------------------------------------------------
// rgbds_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rgbds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/rgbds_div.sv]
// ----------------------------------------------------------------------------
// rgbds_div
// Three restoring dividers sharing one divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rgbds_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rgbds_pkg::GREEN_W-1:0] num_red,
  input  logic [rgbds_pkg::GREEN_W-1:0] num_green,
  input  logic [rgbds_pkg::GREEN_W-1:0] num_blue,
  input  logic [rgbds_pkg::CNT_W-1:0]   den,
  output logic                       done,
  output logic [rgbds_pkg::QUO_W-1:0]   quo_red,
  output logic [rgbds_pkg::QUO_W-1:0]   quo_green,
  output logic [rgbds_pkg::QUO_W-1:0]   quo_blue
);
  import rgbds_pkg::*;

  localparam int STEP_W = $clog2(QUO_W);

  logic [GREEN_W-1:0] rem_r [3];
  logic [GREEN_W-1:0] rem_nxt [3];
  logic [QUO_W-1:0]   quo_r [3];
  logic [QUO_W-1:0]   quo_nxt [3];
  logic [CNT_W-1:0]   den_r;
  logic [STEP_W-1:0]  step_r;
  logic               busy_r;
  logic               done_r;
  logic [GREEN_W-1:0] shifted;

  always_comb begin
    shifted = GREEN_W'(den_r) << step_r;
    for (int i = 0; i < 3; i++) begin
      rem_nxt[i] = rem_r[i];
      quo_nxt[i] = quo_r[i];
      if (rem_r[i] >= shifted) begin
        rem_nxt[i] = rem_r[i] - shifted;
        quo_nxt[i][step_r] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r   <= 1'b1;
        step_r   <= STEP_W'(QUO_W - 1);
        den_r    <= den;
        rem_r[0] <= num_red;
        rem_r[1] <= num_green;
        rem_r[2] <= num_blue;
        for (int i = 0; i < 3; i++) begin
          quo_r[i] <= '0;
        end
      end else if (busy_r) begin
        for (int i = 0; i < 3; i++) begin
          rem_r[i] <= rem_nxt[i];
          quo_r[i] <= quo_nxt[i];
        end
        step_r <= step_r - STEP_W'(1);
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quo_red   = quo_r[0];
  assign quo_green = quo_r[1];
  assign quo_blue  = quo_r[2];

endmodule

[src/rgbds_checker.sv]
// ----------------------------------------------------------------------------
// rgbds_checker
// Port-level checks on the downscaler, bound to the top level.
// ----------------------------------------------------------------------------
module rgbds_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_blue_value,
  input logic [7:0]  out_green_value,
  input logic [7:0]  out_red_value,
  input logic [9:0]  out_column,
  input logic [10:0] out_row
);

  // memory sweep after reset keeps the input held off
  a_stall_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  a_no_out_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // means are widened back to 8 bits by shifting
  a_low_bits_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_blue_value[2:0] == 3'b000) && (out_red_value[2:0] == 3'b000)
                  && (out_green_value[1:0] == 2'b00))
    else $error("colour low bits set");

  a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_column) && $stable(out_row))
    else $error("stalled transfer changed");

endmodule

bind rgb565_box_average_downscaler rgbds_checker u_rgbds_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_blue_value  (out_blue_value),
  .out_green_value (out_green_value),
  .out_red_value   (out_red_value),
  .out_column      (out_column),
  .out_row         (out_row)
);

[verif/tb_rgb565_box_average_downscaler.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb565_box_average_downscaler
// Self-checking bench for the box-average downscaler: configures source and
// target sizes, streams RGB565 frames with random gaps and output stalls,
// and checks every averaged pixel against a behavioural model of the block.
// ----------------------------------------------------------------------------
module tb_rgb565_box_average_downscaler;
  import rgbds_pkg::*;

  localparam int COLS          = 1024;
  localparam int RANDOM_ITEMS  = 1050;
  localparam int LARGE_ITEMS   = 256;
  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [9:0]  column;
    logic [10:0] row;
    logic        last;
  } avg_pixel_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_pixel_word;
  logic        in_frame_start;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_blue_value;
  logic [7:0]  out_green_value;
  logic [7:0]  out_red_value;
  logic [9:0]  out_column;
  logic [10:0] out_row;
  logic        out_frame_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [11:0] cfg_data;

  rgb565_box_average_downscaler u_top (.*);

  // model state
  logic [11:0] src_w_reg, src_h_reg, dst_h_reg;
  logic [10:0] dst_w_reg;
  logic [RED_W-1:0]   red_acc   [COLS];
  logic [GREEN_W-1:0] green_acc [COLS];
  logic [BLUE_W-1:0]  blue_acc  [COLS];
  logic [CNT_W-1:0]   count_acc [COLS];
  int unsigned src_col, src_row, dst_col, dst_row, col_end, row_end;

  avg_pixel_t pending_pixels[$];
  int errors = 0;
  int pixels_sent = 0;
  bit no_idle = 0;
  int quiet_cycles = 0;
  int stall_left = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned eff_src_w();
    return clamp_size(src_w_reg, MAX_SOURCE_WIDTH);
  endfunction

  function automatic int unsigned eff_src_h();
    return clamp_size(src_h_reg, MAX_SOURCE_HEIGHT);
  endfunction

  function automatic int unsigned eff_dst_w();
    int unsigned hi;
    hi = eff_src_w();
    if (hi > COLS) hi = COLS;
    return clamp_size(dst_w_reg, hi);
  endfunction

  function automatic int unsigned eff_dst_h();
    return clamp_size(dst_h_reg, eff_src_h());
  endfunction

  task automatic restart_frame_model();
    for (int i = 0; i < COLS; i++) begin
      red_acc[i] = '0;
      green_acc[i] = '0;
      blue_acc[i] = '0;
      count_acc[i] = '0;
    end
    src_col = 0;
    src_row = 0;
    dst_col = 0;
    dst_row = 0;
    col_end = eff_src_w() / eff_dst_w();
    row_end = eff_src_h() / eff_dst_h();
  endtask

  task automatic downscale_pixel(input logic [15:0] pix, input logic fs);
    int unsigned sw, sh, dw, dh, tc, cnt, rm, gm, bm;
    bit col_last, row_last;
    avg_pixel_t res;
    sw = eff_src_w();
    sh = eff_src_h();
    dw = eff_dst_w();
    dh = eff_dst_h();
    if (fs) restart_frame_model();
    if (dst_col >= dw) dst_col = dw - 1;
    tc = dst_col;
    red_acc[tc] = red_acc[tc] + pix[15:11];
    green_acc[tc] = green_acc[tc] + pix[10:5];
    blue_acc[tc] = blue_acc[tc] + pix[4:0];
    count_acc[tc] = count_acc[tc] + 1;
    col_last = (src_col + 1 >= col_end) || (src_col + 1 >= sw);
    row_last = (src_row + 1 >= row_end) || (src_row + 1 >= sh);
    if (col_last && row_last) begin
      cnt = count_acc[tc];
      rm = 0; gm = 0; bm = 0;
      if (cnt != 0) begin
        rm = red_acc[tc] / cnt;
        gm = green_acc[tc] / cnt;
        bm = blue_acc[tc] / cnt;
      end
      res.blue = 8'(bm << 3);
      res.green = 8'(gm << 2);
      res.red = 8'(rm << 3);
      res.column = 10'(tc);
      res.row = 11'(dst_row);
      res.last = (tc + 1 >= dw) && (dst_row + 1 >= dh);
      pending_pixels.push_back(res);
      red_acc[tc] = '0;
      green_acc[tc] = '0;
      blue_acc[tc] = '0;
      count_acc[tc] = '0;
    end
    src_col++;
    if (src_col >= sw) begin
      src_col = 0;
      dst_col = 0;
      col_end = sw / dw;
      src_row++;
      if (src_row >= sh) begin
        src_row = 0;
        dst_row = 0;
        row_end = sh / dh;
      end else if (row_last) begin
        if (dst_row + 1 < dh) dst_row++;
        row_end = ((dst_row + 1) * sh) / dh;
      end
    end else if (col_last) begin
      if (dst_col + 1 < dw) dst_col++;
      col_end = ((dst_col + 1) * sw) / dw;
    end
  endtask

  task automatic send_pixel(input logic [15:0] pix, input logic fs);
    in_pixel_word <= pix;
    in_frame_start <= fs;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    downscale_pixel(pix, fs);
    pixels_sent++;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [11:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SOURCE_WIDTH:  src_w_reg = val;
      REG_SOURCE_HEIGHT: src_h_reg = val;
      REG_TARGET_WIDTH:  dst_w_reg = val[10:0];
      REG_TARGET_HEIGHT: dst_h_reg = val;
      default: return;
    endcase
    restart_frame_model();
  endtask

  task automatic set_sizes(input logic [11:0] sw, input logic [11:0] sh,
                           input logic [11:0] tw, input logic [11:0] th);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_SOURCE_WIDTH, sw);
    write_reg(REG_SOURCE_HEIGHT, sh);
    write_reg(REG_TARGET_WIDTH, tw);
    write_reg(REG_TARGET_HEIGHT, th);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input bit mark_start);
    int unsigned n;
    n = eff_src_w() * eff_src_h();
    for (int unsigned i = 0; i < n; i++)
      send_pixel(16'($urandom), mark_start && i == 0);
  endtask

  task automatic test_reset_defaults();
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hF800, 1'b0);
  endtask

  task automatic test_field_extremes();
    set_sizes(12'd4, 12'd2, 12'd2, 12'd1);
    send_pixel(16'h07E0, 1'b1);
    send_pixel(16'h001F, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hF800, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    // frame wrap without a start mark
    for (int i = 0; i < 4; i++) send_pixel(16'h5AA5, 1'b0);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(3'd4 + 3'($urandom_range(0, 3)), 12'hFFF);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 4; i++) send_pixel(16'($urandom), 1'b0);
  endtask

  task automatic test_size_clamping();
    set_sizes(12'd0, 12'd0, 12'd0, 12'd0);
    for (int i = 0; i < 3; i++) send_pixel(16'($urandom), 1'b0);
    set_sizes(12'd5, 12'd3, 12'd9, 12'd7);
    send_frame(1'b1);
  endtask

  task automatic test_largest_sizes();
    set_sizes(12'hFFF, 12'd1, 12'hFFF, 12'd1);
    for (int i = 0; i < LARGE_ITEMS; i++) send_pixel(16'($urandom), i == 0);
    set_sizes(12'd1, 12'hFFF, 12'd1, 12'hFFF);
    for (int i = 0; i < LARGE_ITEMS; i++) send_pixel(16'($urandom), i == 0);
  endtask

  task automatic test_random_frames();
    int stop_at, frames, n;
    bit paused;
    paused = 0;
    stop_at = pixels_sent + RANDOM_ITEMS;
    while (pixels_sent < stop_at) begin
      if (pixels_sent > stop_at - 200) no_idle = 1;
      set_sizes(12'($urandom_range(0, 24)), 12'($urandom_range(0, 12)),
                12'($urandom_range(0, 30)), 12'($urandom_range(0, 14)));
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        if ($urandom_range(0, 9) < 8) begin
          send_frame($urandom_range(0, 3) != 0);
        end else begin
          n = $urandom_range(1, 2 * eff_src_w() * eff_src_h());
          for (int i = 0; i < n; i++)
            send_pixel(16'($urandom), $urandom_range(0, 9) == 0);
        end
        if (!paused && pixels_sent > stop_at - RANDOM_ITEMS / 2) begin
          wait_drained();
          paused = 1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || no_idle) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= stall_left > 1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    avg_pixel_t exp_px;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected output transfer at column %0d row %0d", out_column, out_row);
        errors++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_blue_value !== exp_px.blue) begin
          $error("blue_value: expected %0d, got %0d", exp_px.blue, out_blue_value);
          errors++;
        end
        if (out_green_value !== exp_px.green) begin
          $error("green_value: expected %0d, got %0d", exp_px.green, out_green_value);
          errors++;
        end
        if (out_red_value !== exp_px.red) begin
          $error("red_value: expected %0d, got %0d", exp_px.red, out_red_value);
          errors++;
        end
        if (out_column !== exp_px.column) begin
          $error("out_column: expected %0d, got %0d", exp_px.column, out_column);
          errors++;
        end
        if (out_row !== exp_px.row) begin
          $error("out_row: expected %0d, got %0d", exp_px.row, out_row);
          errors++;
        end
        if (out_frame_last !== exp_px.last) begin
          $error("frame_last: expected %0d, got %0d", exp_px.last, out_frame_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel_word = '0;
    in_frame_start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    src_w_reg = 12'd1024;
    src_h_reg = 12'd768;
    dst_w_reg = 11'd800;
    dst_h_reg = 12'd600;
    restart_frame_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_field_extremes();
    test_size_clamping();
    test_largest_sizes();
    test_random_frames();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
src/rgbds_pkg.sv
src/rgbds_ram.sv
src/rgbds_div.sv
src/rgb565_box_average_downscaler.sv
src/rgbds_checker.sv
verif/tb_rgb565_box_average_downscaler.sv
